// ----- rtl/core/pidc_pkg.sv -----
`default_nettype none

package pidc_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_W    = 16;
  localparam int ERR_W       = SAMPLE_W + 1;
  localparam int ISUM_W      = ERR_W + 1;
  localparam int INTEG_W     = 16;
  localparam int OUT_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int OP_W        = ERR_W + 2;
  localparam int PROD_W      = GAIN_W + OP_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int SH_W        = SUM_W - FRAC_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP    = 3'd0,
    REG_GAIN_INTEG   = 3'd1,
    REG_GAIN_DERIV   = 3'd2,
    REG_OUTPUT_LIMIT = 3'd3,
    REG_LOOP_MODE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic [LIMIT_W-1:0]       output_limit;
    logic                     loop_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_prop:    '0,
    gain_integ:   '0,
    gain_deriv:   '0,
    output_limit: '1,
    loop_mode:    1'b0
  };

  typedef struct packed {
    logic                    valid;
    logic signed [ERR_W-1:0] err;
  } err_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/pidc_if.sv -----
`default_nettype none

interface pidc_in_if import pidc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] target;
  logic signed [SAMPLE_W-1:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pidc_front.sv -----
`default_nettype none

module pidc_front import pidc_pkg::*; (
  pidc_in_if.sink   in_ch,
  input  logic      full,
  output err_beat_t push
);

  assign in_ch.ready = !full;
  assign push.valid  = in_ch.valid && !full;
  // error is one bit wider than the samples so it never wraps
  assign push.err    = $signed({in_ch.target[SAMPLE_W-1], in_ch.target})
                     - $signed({in_ch.measured[SAMPLE_W-1], in_ch.measured});

endmodule

`default_nettype wire

// ----- rtl/core/pidc_queue.sv -----
`default_nettype none

module pidc_queue import pidc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  err_beat_t push,
  input  logic      pop,
  output logic      full,
  output err_beat_t head
);

  logic signed [ERR_W-1:0] slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.err   = slot[rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/core/pidc_back.sv -----
`default_nettype none

module pidc_back import pidc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      hist_clear,
  input  err_beat_t head,
  output logic      pop,
  pidc_out_if.source out_ch
);

  // history
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [ERR_W-1:0]   prev_prev_error;
  logic signed [OUT_W-1:0]   accum_output;

  // pipeline
  logic v1, v2, v3, v4;
  logic signed [OP_W-1:0]   op_p, op_i, op_d;
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [SH_W-1:0]   sh;
  logic signed [OUT_W-1:0]  drive;
  logic                     advance;

  // stage 1 terms
  logic signed [OP_W-1:0]    err_x, e1_x, e2_x, d1, d2, integ_x;
  logic signed [OP_W-1:0]    op_p_next, op_i_next, op_d_next;
  logic signed [ISUM_W-1:0]  isum, ilim;
  logic signed [INTEG_W-1:0] integral_next;

  // stage 3 and 4 terms
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh_next, lim_sh, pos_res;
  logic signed [SH_W:0]     acc_x, lim_acc, acc_res;
  logic signed [OUT_W-1:0]  drive_next, accum_next;

  assign advance = !v4 || out_ch.ready;
  assign pop     = advance && head.valid;

  always_comb begin
    err_x = $signed({{(OP_W-ERR_W){head.err[ERR_W-1]}}, head.err});
    e1_x  = $signed({{(OP_W-ERR_W){prev_error[ERR_W-1]}}, prev_error});
    e2_x  = $signed({{(OP_W-ERR_W){prev_prev_error[ERR_W-1]}}, prev_prev_error});
    d1    = err_x - e1_x;
    d2    = err_x - (e1_x <<< 1) + e2_x;

    isum = $signed({{(ISUM_W-INTEG_W){integral_sum[INTEG_W-1]}}, integral_sum})
         + $signed({head.err[ERR_W-1], head.err});
    ilim = $signed({{(ISUM_W-LIMIT_W+1){1'b0}}, cfg.output_limit[LIMIT_W-1:1]});
    priority if (isum > ilim) begin
      integral_next = INTEG_W'(ilim);
    end else if (isum < -ilim) begin
      integral_next = INTEG_W'(-ilim);
    end else begin
      integral_next = INTEG_W'(isum);
    end
    integ_x = $signed({{(OP_W-INTEG_W){integral_next[INTEG_W-1]}}, integral_next});

    if (cfg.loop_mode) begin
      op_p_next = d1;
      op_i_next = err_x;
      op_d_next = d2;
    end else begin
      op_p_next = err_x;
      op_i_next = integ_x;
      op_d_next = d1;
    end
  end

  always_comb begin
    sum = $signed({{(SUM_W-PROD_W){prod_p[PROD_W-1]}}, prod_p})
        + $signed({{(SUM_W-PROD_W){prod_i[PROD_W-1]}}, prod_i})
        + $signed({{(SUM_W-PROD_W){prod_d[PROD_W-1]}}, prod_d});
    // arithmetic shift rounds toward minus infinity
    sh_next = SH_W'(sum >>> FRAC_BITS);

    lim_sh = $signed({{(SH_W-LIMIT_W){1'b0}}, cfg.output_limit});
    priority if (sh > lim_sh) begin
      pos_res = lim_sh;
    end else if (sh < -lim_sh) begin
      pos_res = -lim_sh;
    end else begin
      pos_res = sh;
    end

    acc_x   = $signed({{(SH_W+1-OUT_W){accum_output[OUT_W-1]}}, accum_output})
            + $signed({sh[SH_W-1], sh});
    lim_acc = $signed({{(SH_W+1-LIMIT_W){1'b0}}, cfg.output_limit});
    priority if (acc_x > lim_acc) begin
      acc_res = lim_acc;
    end else if (acc_x < -lim_acc) begin
      acc_res = -lim_acc;
    end else begin
      acc_res = acc_x;
    end

    accum_next = OUT_W'(acc_res);
    drive_next = cfg.loop_mode ? accum_next : OUT_W'(pos_res);
  end

  // history: a register write wipes it, ahead of any update
  always_ff @(posedge clk) begin
    if (rst || hist_clear) begin
      integral_sum    <= '0;
      prev_error      <= '0;
      prev_prev_error <= '0;
      accum_output    <= '0;
    end else begin
      if (pop) begin
        prev_error <= head.err;
        if (cfg.loop_mode) begin
          prev_prev_error <= prev_error;
        end else begin
          integral_sum <= integral_next;
        end
      end
      if (advance && v3 && cfg.loop_mode) begin
        accum_output <= accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= head.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_p   <= op_p_next;
      op_i   <= op_i_next;
      op_d   <= op_d_next;
      prod_p <= $signed(cfg.gain_prop) * op_p;
      prod_i <= $signed(cfg.gain_integ) * op_i;
      prod_d <= $signed(cfg.gain_deriv) * op_d;
      sh     <= sh_next;
      drive  <= drive_next;
    end
  end

  assign out_ch.valid = v4;
  assign out_ch.drive = drive;

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (integral_sum <= ilim) && (integral_sum >= -ilim))
    else $error("integral outside half limit");

  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    (accum_output <= lim_acc) && (accum_output >= -lim_acc))
    else $error("accumulated output outside limit");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (v4 && !out_ch.ready) |=> ($stable({v1, v2, v3}) && $stable(drive)))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// ----- rtl/core/pid_controller_two_forms_core.sv -----
// path: queue slot, then operand, product, shifted-sum and drive registers
// throughput: one beat per cycle unless drive stalls; queue, multiply and clamp stages all run
// the accumulated output recurrence closes over a single add and clamp in the last stage
// reset: synchronous; gains 0, limit 32767, positional form, history and queue cleared
// any write to a listed register also clears integral, error history and accumulated output
`default_nettype none

module pid_controller_two_forms_core import pidc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pidc_in_if.sink               in_ch,
  pidc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      hist_clear;
  err_beat_t push;
  err_beat_t head;
  logic      full;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_PROP:    cfg.gain_prop    <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_INTEG:   cfg.gain_integ   <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_DERIV:   cfg.gain_deriv   <= $signed(cfg_data[GAIN_W-1:0]);
        REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data[LIMIT_W-1:0];
        REG_LOOP_MODE:    cfg.loop_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign hist_clear = cfg_we && (cfg_index <= REG_LOOP_MODE);

  pidc_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push)
  );

  pidc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  pidc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hist_clear (hist_clear),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
